@@ sv/lph_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared widths, operation and status codes, slot marks and state encodings.
// ----------------------------------------------------------------------------
package lph_pkg;

    localparam int KEY_W       = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 4;
    localparam int S_DATA_W    = 40;
    localparam int M_DATA_W    = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_MISSING  = 3'd3,
        ST_FOUND    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_USED  = 2'd1,
        MARK_GONE  = 2'd2
    } mark_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_HASH,
        FR_PUSH
    } fr_state_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_PROBE,
        BK_RESP
    } bk_state_t;

endpackage

@@ sv/lph_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table request queue
// Small first-in first-out buffer between the hashing front and probe engine.
// ----------------------------------------------------------------------------
module lph_fifo import lph_pkg::*; #(
    parameter int WIDTH = 38,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             not_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] buf_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rdata     = buf_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            buf_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ sv/lph_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table front end
// Accepts request words and finds the home slot, the key modulo the slot
// count, through a multiply by a scaled reciprocal, then hands the request
// with its home slot to the queue.
// ----------------------------------------------------------------------------
module lph_front import lph_pkg::*; #(
    parameter  int SLOTS = 16,
    localparam int IW    = $clog2(SLOTS),
    localparam int QW    = OP_W + KEY_W + IW
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                clr_done,
    output logic                q_push,
    input  logic                q_full,
    output logic [QW-1:0]       q_wdata
);

    // The reciprocal of SLOTS scaled by 2^(KEY_W + IW) and rounded up. Its
    // error stays below 2^IW, so the high product bits are the exact quotient
    // of every 32-bit key.
    localparam int             MUL_SHIFT = KEY_W + IW;
    localparam int             PROD_W    = 2 * KEY_W + 1;
    localparam logic [KEY_W:0] RECIP     = (KEY_W + 1)'(
        ((longint'(1) << MUL_SHIFT) + longint'(SLOTS) - longint'(1)) / longint'(SLOTS));

    fr_state_t         state_reg, state_next;
    logic [OP_W-1:0]   op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [KEY_W-1:0]  quot;
    logic [KEY_W-1:0]  home;
    logic              accept;

    assign accept = s_tvalid && s_tready;
    assign quot   = KEY_W'(prod_reg >> MUL_SHIFT);
    assign home   = key_reg - quot * KEY_W'(SLOTS);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE: begin
                if (accept) begin
                    state_next = FR_HASH;
                end
            end
            FR_HASH: begin
                state_next = FR_PUSH;
            end
            FR_PUSH: begin
                if (!q_full) begin
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        q_push   = 1'b0;
        case (state_reg)
            FR_IDLE: s_tready = clr_done;
            FR_PUSH: q_push   = !q_full;
            default: begin
                s_tready = 1'b0;
                q_push   = 1'b0;
            end
        endcase
    end

    assign q_wdata = {home[IW-1:0], key_reg, op_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_tdata[OP_W-1:0];
            key_reg <= s_tdata[OP_W +: KEY_W];
        end
        if (state_reg == FR_HASH) begin
            prod_reg <= PROD_W'(key_reg) * PROD_W'(RECIP);
        end
    end

endmodule

@@ sv/lph_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table probe engine
// Holds the slot memory, walks slots from the home slot one per cycle, applies
// insert and remove, and drives the result register.
// ----------------------------------------------------------------------------
module lph_back import lph_pkg::*; #(
    parameter  int SLOTS = 16,
    localparam int IW    = $clog2(SLOTS),
    localparam int QW    = OP_W + KEY_W + IW
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  logic [QW-1:0]       q_rdata,
    output logic                q_pop,
    output logic                clr_done,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int MW = 2 + KEY_W;

    // Each memory word is {mark, key}.
    logic [MW-1:0]       mem [SLOTS];
    logic [MW-1:0]       rd_data_reg;
    logic [IW-1:0]       rd_addr;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic [MW-1:0]       wr_data;

    bk_state_t           state_reg, state_next;
    logic [IW-1:0]       clr_idx_reg;
    op_t                 op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [IW-1:0]       cnt_reg;
    status_t             status_reg, status_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [SLOT_W-1:0]   m_slot_reg;

    op_t                 q_op;
    logic [KEY_W-1:0]    q_key;
    logic [IW-1:0]       q_home;
    mark_t               rd_mark;
    logic [KEY_W-1:0]    rd_key;
    logic                idx_wrap;
    logic                lap_end;
    logic                q_op_ok;
    logic                probe_done;
    logic                out_free;

    assign q_op     = op_t'(q_rdata[OP_W-1:0]);
    assign q_key    = q_rdata[OP_W +: KEY_W];
    assign q_home   = q_rdata[OP_W + KEY_W +: IW];
    assign rd_mark  = mark_t'(rd_data_reg[MW-1 -: 2]);
    assign rd_key   = rd_data_reg[KEY_W-1:0];
    assign idx_wrap = (idx_reg == IW'(SLOTS - 1));
    assign idx_next = idx_wrap ? '0 : idx_reg + 1'b1;
    assign lap_end  = (cnt_reg == IW'(SLOTS - 1));
    assign out_free = !m_tvalid_reg || m_tready;
    assign q_op_ok  = (q_op == OP_INSERT) || (q_op == OP_REMOVE) || (q_op == OP_SEARCH);

    // Decision on the slot whose word arrived this cycle.
    always_comb begin
        probe_done  = 1'b0;
        status_next = ST_MISSING;
        slot_next   = '0;
        if (op_reg == OP_INSERT) begin
            if (rd_mark != MARK_USED) begin
                probe_done  = 1'b1;
                status_next = ST_INSERTED;
                slot_next   = SLOT_W'(idx_reg);
            end else if (lap_end) begin
                probe_done  = 1'b1;
                status_next = ST_FULL;
            end
        end else begin
            if (rd_mark == MARK_EMPTY) begin
                probe_done = 1'b1;
            end else if (rd_mark == MARK_USED && rd_key == key_reg) begin
                probe_done  = 1'b1;
                status_next = (op_reg == OP_REMOVE) ? ST_REMOVED : ST_FOUND;
                slot_next   = SLOT_W'(idx_reg);
            end else if (lap_end) begin
                probe_done = 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR: begin
                if (clr_idx_reg == IW'(SLOTS - 1)) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (q_valid) begin
                    state_next = q_op_ok ? BK_PROBE : BK_RESP;
                end
            end
            BK_PROBE: begin
                if (probe_done) begin
                    state_next = BK_RESP;
                end
            end
            BK_RESP: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // The next slot is read while the current one is judged, so a walk
    // judges one slot per cycle.
    always_comb begin
        q_pop    = 1'b0;
        clr_done = 1'b1;
        rd_addr  = idx_next;
        wr_en    = 1'b0;
        wr_addr  = idx_reg;
        wr_data  = {MARK_USED, key_reg};
        case (state_reg)
            BK_CLEAR: begin
                clr_done = 1'b0;
                wr_en    = 1'b1;
                wr_addr  = clr_idx_reg;
                wr_data  = {MARK_EMPTY, {KEY_W{1'b0}}};
            end
            BK_IDLE: begin
                q_pop   = q_valid;
                rd_addr = q_home;
            end
            BK_PROBE: begin
                if (probe_done && status_next == ST_INSERTED) begin
                    wr_en = 1'b1;
                end else if (probe_done && status_next == ST_REMOVED) begin
                    wr_en   = 1'b1;
                    wr_data = {MARK_GONE, rd_key};
                end
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_CLEAR;
            clr_idx_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == BK_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (state_reg == BK_RESP && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            BK_IDLE: begin
                op_reg     <= q_op;
                key_reg    <= q_key;
                idx_reg    <= q_home;
                cnt_reg    <= '0;
                status_reg <= ST_MISSING;
                slot_reg   <= '0;
            end
            BK_PROBE: begin
                idx_reg    <= idx_next;
                cnt_reg    <= cnt_reg + 1'b1;
                status_reg <= status_next;
                slot_reg   <= slot_next;
            end
            BK_RESP: begin
                if (out_free) begin
                    m_status_reg <= status_reg;
                    m_slot_reg   <= slot_reg;
                end
            end
            default: begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_slot_reg, m_status_reg};

endmodule

@@ sv/linear_probe_hash_table.sv @@
`timescale 1ns / 1ps
// The number of slots probed per request is none for the unused opcode, else
// 1 to SLOTS; the slot walk reads one memory word per cycle. The hashing front
// and the probe engine work on different requests at once, overlapped through
// a two-entry queue. Reset: synchronous, active low; afterwards a clearing pass
// marks every slot empty, and s_tready stays low until it ends.
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open-addressing hash table with linear probing and tombstones: insert,
// remove and search of 32-bit keys, one result word per request word.
// ----------------------------------------------------------------------------
module linear_probe_hash_table import lph_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // [1:0] op, [33:2] key, [39:34] zero
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // [2:0] status, [6:3] slot, [7] zero
);

    localparam int IW = $clog2(SLOTS);
    localparam int QW = OP_W + KEY_W + IW;

    logic          clr_done;
    logic          q_push;
    logic          q_full;
    logic [QW-1:0] q_wdata;
    logic          q_pop;
    logic [QW-1:0] q_rdata;
    logic          q_valid;

    lph_front #(
        .SLOTS(SLOTS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .clr_done (clr_done),
        .q_push   (q_push),
        .q_full   (q_full),
        .q_wdata  (q_wdata)
    );

    lph_fifo #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_valid)
    );

    lph_back #(
        .SLOTS(SLOTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .clr_done (clr_done),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
